// File: src/hcm_pkg.sv
package hcm_pkg;

   // table and vector geometry
   localparam int ENTRIES      = 64;
   localparam int ID_SPACE     = 1024;
   localparam int VECTOR_WORDS = 4;

   // fixed field widths of the stream words
   localparam int IN_WORDS = 4;
   localparam int WORD_W   = 64;
   localparam int ID_W     = 10;
   localparam int OP_W     = 2;
   localparam int DIST_W   = 9;

   localparam int DIM_BITS   = WORD_W * VECTOR_WORDS;
   localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int MAP_AW     = $clog2(ID_SPACE);
   localparam int LANE_CNT_W = $clog2(WORD_W + 1);

   // stream word layouts
   localparam int REQ_FIELDS_W = ID_W + IN_WORDS * WORD_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_WORD_LSB = 1 + ID_W + DIST_W;
   localparam int RSP_FIELDS_W = RSP_WORD_LSB + IN_WORDS * WORD_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_STORE = 2'd0,
      OP_GET   = 2'd1,
      OP_CLEAN = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAP,
      ST_GET,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef logic [LANE_CNT_W-1:0] lane_cnt_type;
   typedef logic [WORD_W-1:0]     word_type;

   // word memory controls shared by all lanes
   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_slot;
      logic [SLOT_W-1:0] rd_slot;
   } lane_ctl_type;

   // nearest-entry tracker controls
   typedef struct packed {
      logic clear;
      logic sample;
   } merge_ctl_type;

   // set bits of one vector word, byte by byte
   function automatic lane_cnt_type popcount_word(input word_type w);
      logic [3:0]   byte_cnt;
      lane_cnt_type total;
      total = '0;
      for (int b = 0; b < WORD_W / 8; b++) begin
         byte_cnt = '0;
         for (int k = 0; k < 8; k++) begin
            byte_cnt = byte_cnt + 4'(w[b*8+k]);
         end
         total = total + LANE_CNT_W'(byte_cnt);
      end
      return total;
   endfunction

endpackage

// File: src/hcm_ram.sv
module hcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/hcm_lane.sv
module hcm_lane (
   input  logic                        clock,
   input  hcm_pkg::lane_ctl_type       ctl,
   input  hcm_pkg::word_type           query,
   output hcm_pkg::word_type           rd_word,
   output hcm_pkg::lane_cnt_type       count
);
   import hcm_pkg::*;

   lane_cnt_type count_ff;

   // this lane's word of every stored vector
   hcm_ram #(
      .WIDTH(WORD_W),
      .DEPTH(ENTRIES)
   ) u_words (
      .clock  (clock),
      .wr_en  (ctl.wr_en),
      .wr_addr(ctl.wr_slot),
      .wr_data(query),
      .rd_addr(ctl.rd_slot),
      .rd_data(rd_word)
   );

   // hamming distance of this word against the entry just read
   always_ff @(posedge clock) begin
      count_ff <= popcount_word(query ^ rd_word);
   end

   assign count = count_ff;

endmodule

// File: src/hcm_merge.sv
module hcm_merge (
   input  logic                        clock,
   input  hcm_pkg::merge_ctl_type      ctl,
   input  hcm_pkg::lane_cnt_type       lane_count [hcm_pkg::VECTOR_WORDS],
   input  logic [hcm_pkg::ID_W-1:0]    slot_id,
   output logic [hcm_pkg::DIST_W-1:0]  best_dist,
   output logic [hcm_pkg::ID_W-1:0]    best_id
);
   import hcm_pkg::*;

   logic [ID_W-1:0]   id_d_ff;
   logic [DIST_W-1:0] sum;
   logic [DIST_W-1:0] best_dist_ff;
   logic [ID_W-1:0]   best_id_ff;

   // total distance over all lanes
   always_comb begin
      sum = '0;
      for (int w = 0; w < VECTOR_WORDS; w++) begin
         sum = sum + DIST_W'(lane_count[w]);
      end
   end

   // keep the first entry at the least distance
   always_ff @(posedge clock) begin
      id_d_ff <= slot_id;
      if (ctl.clear) begin
         best_dist_ff <= DIST_W'(DIM_BITS + 1);
         best_id_ff   <= '0;
      end else if (ctl.sample && (sum < best_dist_ff)) begin
         best_dist_ff <= sum;
         best_id_ff   <= id_d_ff;
      end
   end

   assign best_dist = best_dist_ff;
   assign best_id   = best_id_ff;

endmodule

// File: src/hypervector_cleanup_memory_top.sv
// Associative clean-up memory for 256-bit binary hypervectors with 64 slots and ids 1 to 1023.
// After reset the whole id map is cleared, during which req_tready stays low. Each word then
// runs from acceptance to the result word in the output register: stores and failed requests
// through the id map lookup, gets through a further read of the word memories, clean-ups
// through a scan of the table and a drain of the compare pipeline (none for an empty table).
// Clean-up time is set by the scan of the table, one stored entry per cycle, all four 64-bit
// vector words read and compared in parallel lanes. One word is worked on at a time; the next
// is taken while the previous result still waits in the output register.
module hypervector_cleanup_memory_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // sym_id, vector_word0, vector_word1, vector_word2, vector_word3, zero fill
   input  logic [hcm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // operation
   input  logic [hcm_pkg::OP_W-1:0]          req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // success, found_id, distance, result_word0, result_word1, result_word2, result_word3,
   // zero fill
   output logic [hcm_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import hcm_pkg::*;

   state_type         state_ff, state_in;
   logic [MAP_AW-1:0] clear_ff;
   logic [OP_W-1:0]   op_ff;
   logic [ID_W-1:0]   id_ff;
   word_type          qry_ff [VECTOR_WORDS];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  scan_ff;
   logic              s1_ff;
   logic              s2_ff;

   logic              res_success_ff;
   logic [ID_W-1:0]   res_id_ff;
   logic [DIST_W-1:0] res_dist_ff;
   word_type          res_word_ff [IN_WORDS];
   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_pack;

   logic              accept;
   word_type          in_word [IN_WORDS];
   logic              id_ok;
   logic              map_hit;
   logic              is_store;
   logic              is_get;
   logic              is_clean;
   logic              store_old;
   logic              store_new;
   logic              get_ok;
   logic              scan_go;
   logic              scan_last;
   logic              clear_last;
   logic              drain_done;
   logic              push;
   logic [SLOT_W-1:0] hit_slot;

   logic              map_we;
   logic [MAP_AW-1:0] map_waddr;
   logic [CNT_W-1:0]  map_wdata;
   logic [CNT_W-1:0]  map_rdata;
   logic              ids_we;
   logic [ID_W-1:0]   ids_rdata;

   lane_ctl_type      lane_ctl;
   merge_ctl_type     merge_ctl;
   word_type          lane_rd [VECTOR_WORDS];
   lane_cnt_type      lane_cnt [VECTOR_WORDS];
   logic [DIST_W-1:0] best_dist;
   logic [ID_W-1:0]   best_id;

   // input word fields
   always_comb begin
      for (int w = 0; w < IN_WORDS; w++) begin
         in_word[w] = req_tdata[ID_W + w*WORD_W +: WORD_W];
      end
   end

   assign accept = req_tvalid && req_tready;

   // request decode against the id map entry
   assign id_ok     = (id_ff != '0) && ({1'b0, id_ff} < (ID_W + 1)'(ID_SPACE));
   assign map_hit   = (map_rdata != '0);
   assign is_store  = (op_ff == OP_STORE);
   assign is_get    = (op_ff == OP_GET);
   assign is_clean  = (op_ff == OP_CLEAN);
   assign store_old = is_store && id_ok && map_hit;
   assign store_new = is_store && id_ok && !map_hit && (count_ff < CNT_W'(ENTRIES));
   assign get_ok    = is_get && id_ok && map_hit;
   assign scan_go   = is_clean && (count_ff != '0);
   assign hit_slot  = SLOT_W'(map_rdata - 1'b1);
   assign scan_last = ((scan_ff + 1'b1) == count_ff);
   assign clear_last = (clear_ff == MAP_AW'(ID_SPACE - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_MAP;
         end
         ST_MAP: begin
            if (get_ok) begin
               state_in = ST_GET;
            end else if (scan_go) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_GET: state_in = ST_DONE;
         ST_SCAN: begin
            if (scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!s1_ff && !s2_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready       = (state_ff == ST_IDLE);
      drain_done       = (state_ff == ST_DRAIN) && !s1_ff && !s2_ff;
      push             = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

      lane_ctl.wr_en   = (state_ff == ST_MAP) && (store_old || store_new);
      lane_ctl.wr_slot = map_hit ? hit_slot : count_ff[SLOT_W-1:0];
      lane_ctl.rd_slot = (state_ff == ST_MAP) ? hit_slot : scan_ff[SLOT_W-1:0];

      map_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_MAP) && store_new);
      map_waddr = (state_ff == ST_CLEAR) ? clear_ff : id_ff[MAP_AW-1:0];
      map_wdata = (state_ff == ST_CLEAR) ? '0 : (count_ff + 1'b1);

      ids_we    = (state_ff == ST_MAP) && store_new;

      merge_ctl.clear  = (state_ff == ST_MAP);
      merge_ctl.sample = s2_ff;
   end

   // id map: slot index plus one, zero when absent
   hcm_ram #(
      .WIDTH(CNT_W),
      .DEPTH(ID_SPACE)
   ) u_id_map (
      .clock  (clock),
      .wr_en  (map_we),
      .wr_addr(map_waddr),
      .wr_data(map_wdata),
      .rd_addr(req_tdata[MAP_AW-1:0]),
      .rd_data(map_rdata)
   );

   // id held by each slot
   hcm_ram #(
      .WIDTH(ID_W),
      .DEPTH(ENTRIES)
   ) u_slot_ids (
      .clock  (clock),
      .wr_en  (ids_we),
      .wr_addr(count_ff[SLOT_W-1:0]),
      .wr_data(id_ff),
      .rd_addr(scan_ff[SLOT_W-1:0]),
      .rd_data(ids_rdata)
   );

   // one lane per vector word
   for (genvar g = 0; g < VECTOR_WORDS; g++) begin : g_lane
      hcm_lane u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .query  (qry_ff[g]),
         .rd_word(lane_rd[g]),
         .count  (lane_cnt[g])
      );
   end

   hcm_merge u_merge (
      .clock     (clock),
      .ctl       (merge_ctl),
      .lane_count(lane_cnt),
      .slot_id   (ids_rdata),
      .best_dist (best_dist),
      .best_id   (best_id)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         count_ff     <= '0;
         scan_ff      <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clear_ff <= clear_ff + 1'b1;
         end
         if ((state_ff == ST_MAP) && store_new) begin
            count_ff <= count_ff + 1'b1;
         end
         if (state_ff == ST_MAP) begin
            scan_ff <= '0;
         end else if (state_ff == ST_SCAN) begin
            scan_ff <= scan_ff + 1'b1;
         end
         s1_ff <= (state_ff == ST_SCAN);
         s2_ff <= s1_ff;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_tuser;
         id_ff <= req_tdata[ID_W-1:0];
         for (int w = 0; w < VECTOR_WORDS; w++) begin
            qry_ff[w] <= (w < IN_WORDS) ? in_word[w] : '0;
         end
      end
   end

   // result fields
   always_ff @(posedge clock) begin
      if (state_ff == ST_MAP) begin
         res_success_ff <= store_old || store_new;
         res_id_ff      <= '0;
         res_dist_ff    <= (is_clean && (count_ff == '0)) ? DIST_W'(DIM_BITS) : '0;
         for (int w = 0; w < IN_WORDS; w++) begin
            res_word_ff[w] <= '0;
         end
      end else if (state_ff == ST_GET) begin
         res_success_ff <= 1'b1;
         for (int w = 0; w < IN_WORDS; w++) begin
            res_word_ff[w] <= (w < VECTOR_WORDS) ? lane_rd[w] : '0;
         end
      end else if (drain_done) begin
         res_success_ff <= 1'b1;
         res_id_ff      <= best_id;
         res_dist_ff    <= best_dist;
      end
   end

   // result word packing
   always_comb begin
      rsp_pack                      = '0;
      rsp_pack[0]                   = res_success_ff;
      rsp_pack[1 +: ID_W]           = res_id_ff;
      rsp_pack[1 + ID_W +: DIST_W]  = res_dist_ff;
      for (int w = 0; w < IN_WORDS; w++) begin
         rsp_pack[RSP_WORD_LSB + w*WORD_W +: WORD_W] = res_word_ff[w];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (push) begin
         rsp_data_ff <= rsp_pack;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: tb/hypervector_cleanup_memory_top_tb.sv
`timescale 1ns / 100ps

module hypervector_cleanup_memory_top_tb;
   import hcm_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int VEC_W       = WORD_W * IN_WORDS;
   localparam int ID_POOL     = 96;
   localparam int TAIL_CYCLES = 2 * ENTRIES + 40;

   typedef logic [VEC_W-1:0] vector_type;

   typedef struct {
      logic              success;
      logic [ID_W-1:0]   found_id;
      logic [DIST_W-1:0] distance;
      vector_type        vec;
   } reply_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [OP_W-1:0]       req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // shadow copy of the id map and the slot table
   int unsigned     id_slot [ID_SPACE];
   vector_type      slot_vec [ENTRIES];
   logic [ID_W-1:0] slot_id [ENTRIES];
   int unsigned     entry_total;

   reply_type       pending_replies [$];
   logic [ID_W-1:0] id_pool [ID_POOL];
   int              error_count     = 0;
   int              req_max_gap     = 3;
   int              rsp_max_stall   = 3;
   int              rsp_hold_cycles = 0;

   hypervector_cleanup_memory_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // expected reply of one request, updating the shadow table
   function automatic reply_type predict_reply(input logic [OP_W-1:0] op,
                                               input logic [ID_W-1:0] id,
                                               input vector_type vec);
      reply_type   r;
      int unsigned best;
      int unsigned d;
      r = '{success: 1'b0, found_id: '0, distance: '0, vec: '0};
      case (op)
         OP_STORE: begin
            if (id != '0 && (id_slot[id] != 0 || entry_total < ENTRIES)) begin
               // new id goes to the end of the table
               if (id_slot[id] == 0) begin
                  slot_id[entry_total] = id;
                  id_slot[id] = entry_total + 1;
                  entry_total++;
               end
               slot_vec[id_slot[id] - 1] = vec;
               r.success = 1'b1;
            end
         end
         OP_GET: begin
            if (id != '0 && id_slot[id] != 0) begin
               r.success = 1'b1;
               r.vec = slot_vec[id_slot[id] - 1];
            end
         end
         OP_CLEAN: begin
            // first entry at the least distance wins
            best = VEC_W + 1;
            for (int i = 0; i < entry_total; i++) begin
               d = $countones(vec ^ slot_vec[i]);
               if (d < best) begin
                  best = d;
                  r.found_id = slot_id[i];
               end
            end
            r.success = (entry_total != 0);
            r.distance = (entry_total == 0) ? DIST_W'(VEC_W) : DIST_W'(best);
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic vector_type random_vector();
      vector_type v;
      for (int k = 0; k < VEC_W / 32; k++) begin
         v[k*32 +: 32] = $urandom;
      end
      return v;
   endfunction

   // query or store vector: random, all zeros or ones, or a stored vector with a few flips
   function automatic vector_type pick_vector();
      vector_type v;
      int         kind;
      int         flips;
      int         pos;
      kind = $urandom_range(0, 9);
      if (entry_total == 0 || kind < 3) begin
         v = random_vector();
      end else if (kind == 3) begin
         v = $urandom_range(0, 1) ? '1 : '0;
      end else begin
         v = slot_vec[$urandom_range(0, entry_total - 1)];
         flips = $urandom_range(0, (kind - 4) * 3);
         for (int f = 0; f < flips; f++) begin
            pos = $urandom_range(0, VEC_W - 1);
            v[pos] = ~v[pos];
         end
      end
      return v;
   endfunction

   function automatic logic [ID_W-1:0] pick_id();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return ID_W'($urandom_range(0, ID_SPACE - 1));
      return id_pool[$urandom_range(0, ID_POOL - 1)];
   endfunction

   // offer one request word and record its expected reply once accepted
   task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                               input vector_type vec);
      int                    gap;
      logic [REQ_DATA_W-1:0] data;
      gap = $urandom_range(0, req_max_gap);
      data = '0;
      data[ID_W-1:0] = id;
      data[ID_W +: VEC_W] = vec;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_replies.push_back(predict_reply(op, id, vec));
   endtask

   task automatic send_random_request();
      int              r;
      logic [OP_W-1:0] op;
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_STORE;
      else if (r < 55) op = OP_GET;
      else if (r < 97) op = OP_CLEAN;
      else op = OP_UNUSED;
      send_request(op, pick_id(), pick_vector());
   endtask

   // stop offering and wait for every outstanding reply
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // lookups, a store with id 0 and an unused operation on an empty table
   task automatic test_empty_table();
      send_request(OP_CLEAN, 10'd0, '0);
      send_request(OP_CLEAN, 10'd3, '1);
      send_request(OP_GET, 10'd1, '0);
      send_request(OP_GET, 10'd1023, '1);
      send_request(OP_GET, 10'd0, '0);
      send_request(OP_STORE, 10'd0, '1);
      send_request(OP_UNUSED, 10'd5, random_vector());
   endtask

   // stores, overwrite, gets and nearest search on a few entries, ties included
   task automatic test_store_and_get();
      vector_type va;
      vector_type vb;
      va = random_vector();
      vb = random_vector();
      send_request(OP_STORE, 10'd1, '1);
      send_request(OP_STORE, 10'd1023, '0);
      send_request(OP_STORE, 10'd512, va);
      send_request(OP_STORE, 10'd7, va);
      send_request(OP_GET, 10'd1, '0);
      send_request(OP_GET, 10'd1023, '1);
      send_request(OP_GET, 10'd512, '0);
      send_request(OP_GET, 10'd7, '0);
      send_request(OP_CLEAN, 10'd0, '1);
      send_request(OP_CLEAN, 10'd0, '0);
      send_request(OP_CLEAN, 10'd0, va);
      send_request(OP_CLEAN, 10'd0, ~va);
      send_request(OP_CLEAN, 10'd0, va ^ 256'h8000_0000_0000_0001_0000_0000_0000_0100);
      send_request(OP_STORE, 10'd1, vb);
      send_request(OP_GET, 10'd1, '0);
      send_request(OP_CLEAN, 10'd0, vb);
      send_request(OP_UNUSED, 10'd512, '1);
      send_request(OP_GET, 10'd512, '0);
      send_request(OP_GET, 10'd0, '1);
      send_request(OP_STORE, 10'd0, vb);
   endtask

   // receiver holds off for a long stretch while requests keep coming, then a full drain
   task automatic test_output_stall();
      req_max_gap = 0;
      rsp_hold_cycles = 300;
      repeat (12) send_random_request();
      drain_replies();
      req_max_gap = 3;
   endtask

   // both sides without idle cycles
   task automatic test_back_to_back();
      req_max_gap = 0;
      rsp_max_stall = 0;
      repeat (150) send_random_request();
      req_max_gap = 3;
      rsp_max_stall = 3;
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_random_request();
   endtask

   // stimulus
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      foreach (id_slot[i]) id_slot[i] = 0;
      entry_total = 0;
      foreach (id_pool[i]) id_pool[i] = ID_W'($urandom_range(1, ID_SPACE - 1));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_store_and_get();
      test_output_stall();
      test_back_to_back();
      test_random_mix(1800);
      drain_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // reply side ready with random stalls and the occasional long hold
   initial begin : receiver
      int wait_cycles;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         wait_cycles = rsp_hold_cycles + $urandom_range(0, rsp_max_stall);
         rsp_hold_cycles = 0;
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // compare each reply word with the oldest expected reply
   always @(posedge clock) begin : reply_check
      reply_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_replies.size() == 0) begin
            $error("reply word with no request outstanding");
            error_count++;
         end else begin
            exp_r = pending_replies.pop_front();
            if (rsp_tdata[0] !== exp_r.success) begin
               $error("success mismatch: expected %0d, got %0d", exp_r.success, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[1 +: ID_W] !== exp_r.found_id) begin
               $error("found_id mismatch: expected %0d, got %0d",
                      exp_r.found_id, rsp_tdata[1 +: ID_W]);
               error_count++;
            end
            if (rsp_tdata[1 + ID_W +: DIST_W] !== exp_r.distance) begin
               $error("distance mismatch: expected %0d, got %0d",
                      exp_r.distance, rsp_tdata[1 + ID_W +: DIST_W]);
               error_count++;
            end
            for (int k = 0; k < IN_WORDS; k++) begin
               if (rsp_tdata[RSP_WORD_LSB + k*WORD_W +: WORD_W] !== exp_r.vec[k*WORD_W +: WORD_W])
               begin
                  $error("result_word%0d mismatch: expected %h, got %h", k,
                         exp_r.vec[k*WORD_W +: WORD_W],
                         rsp_tdata[RSP_WORD_LSB + k*WORD_W +: WORD_W]);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
